// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: opcodes, control character
// codes, cell layout and default screen geometry.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// one cell: character in the upper byte, attribute in the lower byte
	localparam int CELL_W = 16;

	// opcodes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// control characters and fixed values
	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_TAB     = 8'd9;
	localparam int         TAB_STEP     = 8;
	localparam logic [7:0] SCROLL_ATTR  = 8'd7;

endpackage

// ----- rtl/tcw_screen_mem.sv -----
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_mem import tcw_pkg::*; #(
	parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	// write the addressed cell
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// register the read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: puts characters at the cursor, handles newline,
// tab and scrolling, clears the screen and reads back single cells.
// ----------------------------------------------------------------------------
// Sequence: a put or an unused opcode goes from accept straight to the result state,
// a read passes a read state first; a clear runs the fill sweep, a put that scrolls the copy and then the fill.
// Flow: one beat at a time; the next beat is taken the cycle after the result
// is loaded.
// Reset: cursor goes to 0,0 and a sweep writes zero to all COLUMNS*ROWS cells,
// one per cycle, before the first beat is accepted.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [3:0]  fg_color,
	input  logic [3:0]  bg_color,
	input  logic [6:0]  read_col,
	input  logic [4:0]  read_row,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [10:0] cursor_pos,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = (AW > 11) ? AW : 11;
	localparam int CW    = $clog2(COLUMNS);
	localparam int TW    = $clog2(COLUMNS + TAB_STEP);
	localparam int RW    = (ROWS > 2) ? $clog2(ROWS) : 1;
	localparam int RW1   = $clog2(ROWS + 1);

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_SCROLL,
		ST_SCROLL_END,
		ST_READ,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cursor_col_q;
	logic [RW-1:0]     cursor_row_q;
	logic [AW-1:0]     fill_q;
	logic [7:0]        fill_attr_q;
	logic [AW-1:0]     scr_q;
	logic              pend_s1;
	logic [AW-1:0]     wa_s1;
	logic              item_q;
	logic              rd_ok_q;
	logic [CELL_W-1:0] rd_q;
	logic              rsp_valid_q;
	logic [10:0]       cursor_pos_q;
	logic [7:0]        cell_char_q;
	logic [7:0]        cell_attr_q;

	logic              accept;
	logic [7:0]        attr;
	logic              is_nl;
	logic              is_tab;
	logic              is_char;
	logic [TW-1:0]     col_sum;
	logic              wrap;
	logic [CW-1:0]     next_col;
	logic [RW1-1:0]    next_row;
	logic              scroll;
	logic [AW-1:0]     cur_lin;
	logic [PW-1:0]     cur_lin_w;
	logic              rd_in_range;
	logic [AW-1:0]     rd_addr;
	logic              rsp_free;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	assign req_stall  = (state_q != ST_IDLE);
	assign accept     = req_valid && !req_stall;
	assign attr       = {bg_color, fg_color};
	assign rsp_free   = !rsp_valid_q || !rsp_stall;

	// work out the cursor move for a put
	assign is_nl   = (char_code == CODE_NEWLINE);
	assign is_tab  = (char_code == CODE_TAB);
	assign is_char = !is_nl && !is_tab;
	assign col_sum = TW'(cursor_col_q) + (is_tab ? TW'(TAB_STEP) : TW'(1));
	assign wrap    = is_nl || (col_sum >= TW'(COLUMNS));
	assign next_col = wrap ? '0 : CW'(col_sum);
	assign next_row = wrap ? (RW1'(cursor_row_q) + RW1'(1)) : RW1'(cursor_row_q);
	assign scroll   = (next_row == RW1'(ROWS));

	// linear cursor index
	assign cur_lin   = AW'(cursor_row_q) * AW'(COLUMNS) + AW'(cursor_col_q);
	assign cur_lin_w = PW'(cur_lin);

	// read address and range check
	assign rd_in_range = ({1'b0, read_col} < 8'(COLUMNS)) && ({2'b0, read_row} < 7'(ROWS));
	assign rd_addr     = AW'(read_row) * AW'(COLUMNS) + AW'(read_col);

	// select the store write: scroll copy, fill sweep, then character put
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_lin;
		mem_wdata = {char_code, attr};
		if (pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wa_s1;
			mem_wdata = mem_rdata;
		end else if (state_q == ST_FILL) begin
			mem_we    = 1'b1;
			mem_waddr = fill_q;
			mem_wdata = {8'h00, fill_attr_q};
		end else if (accept && (opcode == OP_PUT) && is_char) begin
			mem_we    = 1'b1;
		end
	end

	assign mem_raddr = (state_q == ST_SCROLL) ? scr_q : rd_addr;

	tcw_screen_mem #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequence the store walks and hold the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			fill_q       <= '0;
			fill_attr_q  <= '0;
			scr_q        <= '0;
			pend_s1      <= 1'b0;
			wa_s1        <= '0;
			item_q       <= 1'b0;
			rd_ok_q      <= 1'b0;
			rd_q         <= '0;
			rsp_valid_q  <= 1'b0;
			cursor_pos_q <= '0;
			cell_char_q  <= '0;
			cell_attr_q  <= '0;
		end else begin
			pend_s1 <= (state_q == ST_SCROLL);
			wa_s1   <= scr_q - AW'(COLUMNS);
			// raise the result beat when loaded, drop it once taken
			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q <= 1'b1;
						rd_q   <= '0;
						unique case (opcode)
							OP_PUT: begin
								cursor_col_q <= next_col;
								if (scroll) begin
									cursor_row_q <= RW'(ROWS - 1);
									scr_q        <= AW'(COLUMNS);
									state_q      <= ST_SCROLL;
								end else begin
									cursor_row_q <= RW'(next_row);
									state_q      <= ST_DONE;
								end
							end
							OP_CLEAR: begin
								fill_q      <= '0;
								fill_attr_q <= attr;
								state_q     <= ST_FILL;
							end
							OP_READ: begin
								rd_ok_q <= rd_in_range;
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCROLL: begin
					// advance the copy source; the write follows in the next cycle
					scr_q <= scr_q + AW'(1);
					if (scr_q == AW'(CELLS - 1)) begin
						state_q <= ST_SCROLL_END;
					end
				end
				ST_SCROLL_END: begin
					// blank the new bottom row
					fill_q      <= AW'((ROWS - 1) * COLUMNS);
					fill_attr_q <= SCROLL_ATTR;
					state_q     <= ST_FILL;
				end
				ST_FILL: begin
					fill_q <= fill_q + AW'(1);
					if (fill_q == AW'(CELLS - 1)) begin
						state_q <= item_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_READ: begin
					rd_q    <= rd_ok_q ? mem_rdata : '0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// load the result beat once the output register is free
					if (rsp_free) begin
						cursor_pos_q <= cur_lin_w[10:0];
						cell_char_q  <= rd_q[15:8];
						cell_attr_q  <= rd_q[7:0];
						item_q       <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_char  = cell_char_q;
	assign cell_attr  = cell_attr_q;

endmodule
